[hdl/sfd_pkg.sv]
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int unsigned MaxFrameBytes = 4096;
    localparam int unsigned CapWidth      = 13;
    localparam int unsigned PosWidth      = 12;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [CapWidth-1:0] CAP_LIMIT = CapWidth'(MaxFrameBytes);

    typedef enum logic [1:0] {
        MODE_DECODE = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_DROP   = 2'd2
    } t_rx_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_VIOLATION = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic                byte_valid;
        logic [7:0]          payload_byte;
        logic [PosWidth-1:0] byte_position;
        logic                frame_done;
        logic [PosWidth-1:0] frame_length;
    } t_result;

endpackage

[hdl/sfd_if.sv]
`timescale 1ns / 1ps

interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic [11:0] byte_position;
    logic        frame_done;
    logic [11:0] frame_length;

    modport source (output valid, output status, output byte_valid, output payload_byte,
                    output byte_position, output frame_done, output frame_length,
                    input ready);
    modport sink (input valid, input status, input byte_valid, input payload_byte,
                  input byte_position, input frame_done, input frame_length,
                  output ready);
endinterface

interface sfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] frame_capacity;

    modport source (output valid, output frame_capacity, input ready);
    modport sink (input valid, input frame_capacity, output ready);
endinterface

[hdl/sfd_step.sv]
`timescale 1ns / 1ps

module sfd_step (
    input  sfd_pkg::t_rx_mode                  i_mode,
    input  logic [sfd_pkg::CapWidth-1:0]       i_index,
    input  logic [sfd_pkg::CapWidth-1:0]       i_capacity,
    input  logic [7:0]                         i_byte,
    output sfd_pkg::t_rx_mode                  o_mode,
    output logic [sfd_pkg::CapWidth-1:0]       o_index,
    output sfd_pkg::t_result                   o_result
);
    import sfd_pkg::*;

    logic [CapWidth-1:0] w_usable;
    logic [CapWidth-1:0] w_index_inc;

    assign w_usable    = (i_capacity > CAP_LIMIT) ? CAP_LIMIT : i_capacity;
    assign w_index_inc = i_index + CapWidth'(1);

    always_comb begin
        o_mode   = i_mode;
        o_index  = i_index;
        o_result = '0;
        o_result.status = ST_OK;

        if (i_index >= w_usable) begin
            o_index         = '0;
            o_result.status = ST_OVERFLOW;
        end else begin
            case (i_mode)
                MODE_ESCAPE: begin
                    if (i_byte == SLIP_ESC_END || i_byte == SLIP_ESC_ESC) begin
                        o_result.byte_valid    = 1'b1;
                        o_result.payload_byte  = (i_byte == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
                        o_result.byte_position = i_index[PosWidth-1:0];
                        o_index                = w_index_inc;
                        o_mode                 = MODE_DECODE;
                    end else begin
                        o_mode          = MODE_DROP;
                        o_result.status = ST_VIOLATION;
                    end
                end
                MODE_DROP: begin
                    if (i_byte == SLIP_END) begin
                        o_mode  = MODE_DECODE;
                        o_index = '0;
                    end
                end
                default: begin
                    o_mode = MODE_DECODE;
                    if (i_byte == SLIP_END) begin
                        o_result.frame_done   = 1'b1;
                        o_result.frame_length = i_index[PosWidth-1:0];
                        o_index               = '0;
                    end else if (i_byte == SLIP_ESC) begin
                        o_mode = MODE_ESCAPE;
                    end else begin
                        o_result.byte_valid    = 1'b1;
                        o_result.payload_byte  = i_byte;
                        o_result.byte_position = i_index[PosWidth-1:0];
                        o_index                = w_index_inc;
                    end
                end
            endcase
        end
    end

endmodule

[hdl/slip_frame_decoder_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Contents
// i_rx      in         rx_byte, one encoded byte per request
// o_res     out        status, byte_valid, payload_byte, byte_position, frame_done, frame_length
// i_cfg     in         frame_capacity, always ready
//
// Each accepted byte yields one result in the next cycle; one byte per cycle unless stalled.
// The decoder state and the result register are updated in the same cycle as acceptance.
// Reset returns the decoder to normal decoding, clears the index and sets the capacity to 4096.
// While a result is held by a stalled sink, the next byte is accepted only when it is taken.

module slip_frame_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfd_rx_if.sink      i_rx,
    sfd_res_if.source   o_res,
    sfd_cfg_if.sink     i_cfg
);
    import sfd_pkg::*;

    t_rx_mode            r_mode;
    t_rx_mode            n_mode;
    logic [CapWidth-1:0] r_index;
    logic [CapWidth-1:0] n_index;
    logic [CapWidth-1:0] r_capacity;
    logic                r_valid;
    t_result             r_result;
    t_result             n_result;
    logic                w_accept;

    sfd_step u_step (
        .i_mode     (r_mode),
        .i_index    (r_index),
        .i_capacity (r_capacity),
        .i_byte     (i_rx.rx_byte),
        .o_mode     (n_mode),
        .o_index    (n_index),
        .o_result   (n_result)
    );

    assign i_rx.ready  = !r_valid || o_res.ready;
    assign w_accept    = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_DECODE;
            r_index    <= '0;
            r_capacity <= CAP_LIMIT;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.frame_capacity;
            end
            if (w_accept) begin
                r_mode  <= n_mode;
                r_index <= n_index;
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.status        = r_result.status;
    assign o_res.byte_valid    = r_result.byte_valid;
    assign o_res.payload_byte  = r_result.payload_byte;
    assign o_res.byte_position = r_result.byte_position;
    assign o_res.frame_done    = r_result.frame_done;
    assign o_res.frame_length  = r_result.frame_length;

endmodule

[hdl/sfd_checker.sv]
`timescale 1ns / 1ps

module sfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_status,
    input logic        i_byte_valid,
    input logic [7:0]  i_payload_byte,
    input logic        i_frame_done,
    input logic [11:0] i_byte_position
);
    import sfd_pkg::*;

    // A result carries at most one of a payload byte and a frame end.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_byte_valid && i_frame_done))
        else $error("payload byte and frame end in one result");

    // An error result carries neither a payload byte nor a frame end.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_status != ST_OK) |-> (!i_byte_valid && !i_frame_done))
        else $error("error result carries data");

    // A result without a payload byte leaves the byte and its position at zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_byte_valid) |->
        (i_payload_byte == 8'd0 && i_byte_position == 12'd0))
        else $error("byte fields set without a payload byte");

    // A stalled result keeps its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        (i_res_valid && $stable(i_status) && $stable(i_payload_byte)
         && $stable(i_byte_position)))
        else $error("stalled result changed");

    // The status code is never the unused value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_status == ST_OK || i_status == ST_OVERFLOW
                         || i_status == ST_VIOLATION))
        else $error("unused status code");

endmodule

bind slip_frame_decoder_core sfd_checker u_sfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_status        (o_res.status),
    .i_byte_valid    (o_res.byte_valid),
    .i_payload_byte  (o_res.payload_byte),
    .i_frame_done    (o_res.frame_done),
    .i_byte_position (o_res.byte_position)
);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sfd_pkg::*;

    localparam int CycleLimit  = 600000;
    localparam int RandomItems = 1800;
    localparam int HoldCycles  = 400;

    class deframe_board;
        logic [12:0] capacity;
        t_rx_mode    mode;
        logic [12:0] write_idx;
        t_result     due_results[$];
        int          errors;
        int          noted;
        int          dropped;
        int          checked;
        int          frames;
        int          overflows;
        int          violations;

        function new();
            capacity   = 13'(MaxFrameBytes);
            mode       = MODE_DECODE;
            write_idx  = '0;
            errors     = 0;
            noted      = 0;
            dropped    = 0;
            checked    = 0;
            frames     = 0;
            overflows  = 0;
            violations = 0;
        endfunction

        function void set_capacity(logic [12:0] value);
            capacity = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Works out the result of one accepted byte and queues it.
        function void note_byte(logic [7:0] rx_byte);
            t_result     r;
            logic [12:0] usable;
            logic [7:0]  decoded;
            bit          emit;
            r       = '0;
            emit    = 1'b0;
            decoded = '0;
            usable  = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
            noted++;
            if (write_idx >= usable) begin
                write_idx = '0;
                r.status  = ST_OVERFLOW;
                overflows++;
            end else begin
                case (mode)
                    MODE_ESCAPE: begin
                        if (rx_byte == SLIP_ESC_END) begin
                            emit    = 1'b1;
                            decoded = SLIP_END;
                            mode    = MODE_DECODE;
                        end else if (rx_byte == SLIP_ESC_ESC) begin
                            emit    = 1'b1;
                            decoded = SLIP_ESC;
                            mode    = MODE_DECODE;
                        end else begin
                            mode     = MODE_DROP;
                            r.status = ST_VIOLATION;
                            violations++;
                        end
                    end
                    MODE_DROP: begin
                        if (rx_byte == SLIP_END) begin
                            mode      = MODE_DECODE;
                            write_idx = '0;
                        end else begin
                            dropped++;
                        end
                    end
                    default: begin
                        mode = MODE_DECODE;
                        if (rx_byte == SLIP_END) begin
                            r.frame_done   = 1'b1;
                            r.frame_length = write_idx[11:0];
                            write_idx      = '0;
                            frames++;
                        end else if (rx_byte == SLIP_ESC) begin
                            mode = MODE_ESCAPE;
                        end else begin
                            emit    = 1'b1;
                            decoded = rx_byte;
                        end
                    end
                endcase
            end
            if (emit) begin
                r.byte_valid    = 1'b1;
                r.payload_byte  = decoded;
                r.byte_position = write_idx[11:0];
                write_idx       = write_idx + 13'd1;
            end
            due_results.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned seen);
            if (want != seen) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, seen);
            end
        endfunction

        function void check_result(t_result seen);
            t_result want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none actual %h",
                         $time, seen);
                return;
            end
            want = due_results.pop_front();
            checked++;
            compare_field("status", 32'(want.status), 32'(seen.status));
            compare_field("byte_valid", 32'(want.byte_valid), 32'(seen.byte_valid));
            compare_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
            compare_field("byte_position", 32'(want.byte_position),
                          32'(seen.byte_position));
            compare_field("frame_done", 32'(want.frame_done), 32'(seen.frame_done));
            compare_field("frame_length", 32'(want.frame_length), 32'(seen.frame_length));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfd_rx_if  rx ();
    sfd_res_if res ();
    sfd_cfg_if cfg ();

    deframe_board board = new();

    bit gaps_on       = 1'b1;
    bit pressure_done = 1'b0;
    int pressure_at   = 32'h7fff_ffff;
    int hold_left     = 0;
    int cycles        = 0;
    int cap_writes    = 0;

    slip_frame_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: checks every accepted result; holds off at random with gaps on, and for one long hold.
    initial begin
        t_result seen;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                seen.status        = t_status'(res.status);
                seen.byte_valid    = res.byte_valid;
                seen.payload_byte  = res.payload_byte;
                seen.byte_position = res.byte_position;
                seen.frame_done    = res.frame_done;
                seen.frame_length  = res.frame_length;
                board.check_result(seen);
            end
            if (!pressure_done && board.noted >= pressure_at) begin
                pressure_done = 1'b1;
                hold_left     = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= !gaps_on || ($urandom_range(99) >= 12);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while (gaps_on && $urandom_range(99) < 12) begin
            rx.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= value;
        do @(posedge i_clk); while (!rx.ready);
        board.note_byte(value);
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic write_capacity(input logic [12:0] value);
        rx.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        cfg.valid          <= 1'b1;
        cfg.frame_capacity <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        board.set_capacity(value);
        cap_writes++;
    endtask

    task automatic send_payload(input logic [7:0] value);
        if (value == SLIP_END) begin
            send_byte(SLIP_ESC);
            send_byte(SLIP_ESC_END);
        end else if (value == SLIP_ESC) begin
            send_byte(SLIP_ESC);
            send_byte(SLIP_ESC_ESC);
        end else begin
            send_byte(value);
        end
    endtask

    // A broken frame of nonzero length carries an invalid escape halfway through.
    task automatic send_frame(input int len, input bit broken);
        logic [7:0] p;
        int         r;
        for (int i = 0; i < len; i++) begin
            if (broken && i == len / 2) begin
                p = 8'($urandom_range(255));
                if (p == SLIP_ESC_END || p == SLIP_ESC_ESC) p = SLIP_END;
                send_byte(SLIP_ESC);
                send_byte(p);
            end
            r = $urandom_range(99);
            if (r < 8) p = SLIP_END;
            else if (r < 16) p = SLIP_ESC;
            else p = 8'($urandom_range(255));
            send_payload(p);
        end
        send_byte(SLIP_END);
    endtask

    task automatic send_noise(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 25) send_byte(SLIP_END);
            else if (r < 50) send_byte(SLIP_ESC);
            else if (r < 62) send_byte(SLIP_ESC_END);
            else if (r < 75) send_byte(SLIP_ESC_ESC);
            else send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [12:0] cap;
        int          phase_end;
        int          max_len;
        int          r;
        rx.valid           <= 1'b0;
        rx.rx_byte         <= '0;
        cfg.valid          <= 1'b0;
        cfg.frame_capacity <= '0;
        i_rst_n            <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_seq('{8'h00, 8'hFF, 8'h55, 8'hAA, SLIP_END, SLIP_END,
                   SLIP_ESC, SLIP_ESC_END, SLIP_ESC, SLIP_ESC_ESC, SLIP_ESC_END,
                   SLIP_ESC_ESC, SLIP_END, SLIP_ESC, 8'h41, 8'h12, SLIP_ESC, SLIP_END,
                   SLIP_ESC, SLIP_END, 8'h01, SLIP_END, 8'h7E, 8'h3C, SLIP_ESC});
        // Shrinking the buffer while an escape is pending makes it overflow in that mode.
        write_capacity(13'd1);
        send_seq('{SLIP_ESC_END, SLIP_ESC_ESC, 8'h44, SLIP_ESC, 8'h99, 8'h33, SLIP_END});
        write_capacity(13'd0);
        send_seq('{8'h20, SLIP_END, SLIP_ESC});

        // A long frame at the largest capacity value, clamped to 4096, carries the position past eight bits.
        write_capacity(13'd8191);
        send_frame(700, 1'b0);

        for (int phase = 0; board.noted < RandomItems; phase++) begin
            case (phase)
                0: cap = 13'd4096;
                1: cap = 13'd1;
                2: cap = 13'd2;
                3: cap = 13'd8191;
                4: cap = 13'd0;
                default: begin
                    r = $urandom_range(99);
                    if (r < 6) cap = 13'd0;
                    else if (r < 14) cap = 13'd4096;
                    else if (r < 20) cap = 13'd8191;
                    else cap = 13'($urandom_range(64, 1));
                end
            endcase
            write_capacity(cap);
            gaps_on = !(phase == 2 || phase == 3);
            if (phase == 1) pressure_at = board.noted + 60;
            phase_end = board.noted + ((cap == 0) ? 40 : 150);
            if (cap == 0) max_len = 4;
            else if (cap <= 64) max_len = cap + 2;
            else max_len = 48;
            while (board.noted < phase_end) begin
                r = $urandom_range(99);
                if (r < 80) send_frame($urandom_range(max_len), 1'b0);
                else if (r < 90) send_frame($urandom_range(max_len), 1'b1);
                else send_noise($urandom_range(6, 1));
            end
        end
        gaps_on = 1'b1;

        rx.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("Run covered %0d bytes (%0d dropped) and %0d checked results: %0d frames,",
                 board.noted, board.dropped, board.checked, board.frames);
        $display("%0d overflows, %0d bad escapes, %0d capacity writes, one long result hold.",
                 board.overflows, board.violations, cap_writes);
        if (board.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
